@@ hdl/estg_pkg.sv @@
// Shared types, constants and the sine table for the enveloped sine tone generator.
package estg_pkg;

  localparam int unsigned PhaseW  = 4;
  localparam int unsigned CyclesW = 16;
  localparam int unsigned EnvW    = 15;
  localparam int unsigned DacW    = 8;

  // Item function codes
  localparam logic FuncTick = 1'b0;
  localparam logic FuncLoad = 1'b1;

  localparam logic [PhaseW-1:0] LastPhase   = 4'd15;
  localparam logic [EnvW-1:0]   EnvMax      = 15'd32767;
  localparam logic [EnvW-1:0]   DecayReset  = 15'd37;
  localparam logic [DacW-1:0]   DacMid      = 8'h80;

  typedef struct packed {
    logic               func;
    logic [CyclesW-1:0] note_cycles;
    logic [EnvW-1:0]    start_envelope;
  } in_item_t;

  typedef struct packed {
    logic [DacW-1:0] dac_sample;
    logic            note_active;
  } out_item_t;

  // One full sine cycle, signed, peak 126.
  function automatic logic signed [7:0] sine_entry(input logic [PhaseW-1:0] idx);
    logic signed [7:0] val;
    case (idx)
      4'd0:    val = 8'sd48;
      4'd1:    val = 8'sd89;
      4'd2:    val = 8'sd116;
      4'd3:    val = 8'sd126;
      4'd4:    val = 8'sd116;
      4'd5:    val = 8'sd89;
      4'd6:    val = 8'sd48;
      4'd7:    val = 8'sd0;
      4'd8:    val = -8'sd48;
      4'd9:    val = -8'sd89;
      4'd10:   val = -8'sd116;
      4'd11:   val = -8'sd126;
      4'd12:   val = -8'sd116;
      4'd13:   val = -8'sd89;
      4'd14:   val = -8'sd48;
      default: val = 8'sd0;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/estg_sample.sv @@
// Sample datapath: table lookup, envelope scaling and offset to DAC code.
module estg_sample import estg_pkg::*; (
  input  logic [PhaseW-1:0] phase_i,
  input  logic [EnvW-1:0]   envelope_i,
  output logic [DacW-1:0]   dac_sample_o
);

  logic signed [7:0]  entry;
  logic signed [7:0]  env_hi;
  logic signed [15:0] prod;
  logic signed [15:0] scaled;

  assign entry  = sine_entry(phase_i);
  // top seven envelope bits, never negative
  assign env_hi = signed'({1'b0, envelope_i[EnvW-1:EnvW-7]});
  assign prod   = 16'(entry * env_hi);
  // arithmetic shift floors toward minus infinity
  assign scaled = prod >>> 7;
  assign dac_sample_o = scaled[DacW-1:0] + DacMid;

endmodule

@@ hdl/estg_state.sv @@
// Note state: phase, remaining cycles and envelope, with their update rules.
module estg_state import estg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  in_item_t          item_i,
  input  logic [EnvW-1:0]   decay_step_i,
  output logic [PhaseW-1:0] phase_o,
  output logic [EnvW-1:0]   envelope_o,
  output logic              note_active_o
);

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [CyclesW-1:0] cycles_q, cycles_d;
  logic [EnvW-1:0]    env_q, env_d;

  always_comb begin
    phase_d  = phase_q;
    cycles_d = cycles_q;
    env_d    = env_q;
    if (item_i.func == FuncLoad) begin
      cycles_d = item_i.note_cycles;
      env_d    = item_i.start_envelope;
    end else if (phase_q != LastPhase) begin
      phase_d = phase_q + 4'd1;
    end else if (cycles_q != '0) begin
      phase_d  = '0;
      cycles_d = cycles_q - 16'd1;
      if (env_q > decay_step_i) begin
        env_d = env_q - decay_step_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= LastPhase;
      cycles_q <= '0;
      env_q    <= EnvMax;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      cycles_q <= cycles_d;
      env_q    <= env_d;
    end
  end

  assign phase_o       = phase_q;
  assign envelope_o    = env_q;
  assign note_active_o = (cycles_d != '0);

endmodule

@@ hdl/enveloped_sine_tone_generator_unit.sv @@
// Top level of the enveloped sine tone generator.
//
// Each accepted item is either a sample tick or a note load. A tick produces
// one result: an 8-bit offset-binary DAC sample taken from a 16-step signed
// sine table, scaled by the top seven envelope bits (floor of product / 128,
// plus 128), and a flag telling whether cycles remain after this tick. The
// phase moves to the next table step on each tick; at the end of a
// cycle with cycles left, a new cycle starts, the count drops and the
// envelope falls by decay_step unless it is already at or below the step;
// with no cycles left the phase stays on the last step. A load sets the
// remaining cycle count and the envelope and produces no result; the phase
// is kept, so a note loaded mid-cycle first finishes that cycle. Items pass
// through an input register and a result register, so the result of a tick
// is written to the result register as the tick leaves the input register,
// and one item can be accepted every cycle while the result side keeps up.
// A tick waits in the input register while the result register is full and
// not being taken, so in_ready_o follows out_ready_i combinationally in that
// case; a load never waits on the result side. decay_step resets to 37 and
// may be written through cfg_we_i / cfg_wdata_i while no item is in flight.
module enveloped_sine_tone_generator_unit import estg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [EnvW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  logic [EnvW-1:0] decay_step_q;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic              out_free;
  logic              s1_adv;
  logic              s1_tick;
  logic [PhaseW-1:0] phase;
  logic [EnvW-1:0]   envelope;
  logic              note_active;
  logic [DacW-1:0]   dac_sample;

  // Decay step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_step_q <= DecayReset;
    end else if (cfg_we_i) begin
      decay_step_q <= cfg_wdata_i;
    end
  end

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_tick  = (s1_item_q.func == FuncTick);
  // A load never needs the result side; a tick waits for a free result slot.
  assign s1_adv     = s1_valid_q && (!s1_tick || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Input register: hold the item until its work is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  estg_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (s1_adv),
    .item_i        (s1_item_q),
    .decay_step_i  (decay_step_q),
    .phase_o       (phase),
    .envelope_o    (envelope),
    .note_active_o (note_active)
  );

  // Sample uses the phase and envelope before this tick's update.
  estg_sample u_sample (
    .phase_i      (phase),
    .envelope_i   (envelope),
    .dac_sample_o (dac_sample)
  );

  // Result register: load on a tick, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_tick) begin
      out_item_q.dac_sample  <= dac_sample;
      out_item_q.note_active <= note_active;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
